// ===== src/spfe_pkg.sv =====
// Shared constants, codes and types of the softened potential field evaluator.
// No dependencies; every module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package spfe_pkg;

  localparam int MAX_BODIES = 64;
  localparam int IDX_W      = $clog2(MAX_BODIES);

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_EVAL   = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  localparam logic REG_COUPLING  = 1'b0;
  localparam logic REG_SOFTENING = 1'b1;

  localparam logic [23:0] COUPLING_RST  = 24'd3277;
  localparam logic [31:0] SOFTENING_RST = 32'd262144;

  localparam logic [47:0] MAG_LIMIT = 48'h8000_0000_0000;

  typedef struct packed {
    logic        valid;
    logic [31:0] x;
    logic [31:0] z;
    logic [31:0] mass;
  } body_t;

  typedef struct packed {
    logic start;
  } unit_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

// ===== src/spfe_cell.sv =====
// One storage cell of the body chain: holds a body and its valid bit.
// Depends on spfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spfe_cell
  import spfe_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  logic  clear_i,
  input  body_t body_i,
  output body_t body_o
);

  logic        valid_q;
  logic [31:0] x_q, z_q, mass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= body_i.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      x_q    <= body_i.x;
      z_q    <= body_i.z;
      mass_q <= body_i.mass;
    end
  end

  assign body_o = '{valid: valid_q, x: x_q, z: z_q, mass: mass_q};

endmodule

`default_nettype wire

// ===== src/spfe_sqrt.sv =====
// Bit-serial integer square root: 64-bit radicand, 32-bit floor root,
// one root bit per cycle. Depends on spfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spfe_sqrt
  import spfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  unit_ctrl_t  ctrl_i,
  input  logic [63:0] rad_i,
  output unit_stat_t  stat_o,
  output logic [31:0] root_o
);

  logic [63:0] rad_q, rad_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [33:0] rem_sh, trial;

  always_comb begin
    rem_sh = {rem_q[31:0], rad_q[63:62]};
    trial  = {root_q, 2'b01};
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign root_o = root_q;

endmodule

`default_nettype wire

// ===== src/spfe_div.sv =====
// Restoring divider: 56-bit dividend by 32-bit nonzero divisor, one quotient
// bit per cycle. Depends on spfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spfe_div
  import spfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  unit_ctrl_t  ctrl_i,
  input  logic [55:0] dividend_i,
  input  logic [31:0] divisor_i,
  output unit_stat_t  stat_o,
  output logic [55:0] quot_o
);

  logic [55:0] dvd_q, dvd_d;
  logic [31:0] dvs_q, dvs_d;
  logic [31:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] rem_sh, diff;

  always_comb begin
    rem_sh = {rem_q, dvd_q[55]};
    diff   = rem_sh - {1'b0, dvs_q};
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // quotient bits shift in behind the dividend bits
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = diff[31:0];
        dvd_d = {dvd_q[54:0], 1'b1};
      end else begin
        rem_d = rem_sh[31:0];
        dvd_d = {dvd_q[54:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd55) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quot_o = dvd_q;

endmodule

`default_nettype wire

// ===== src/softened_potential_field_eval_unit.sv =====
// Softened potential field evaluator, top level. Depends on spfe_pkg, spfe_cell,
// spfe_sqrt and spfe_div.
//
// Bodies live in a ring of MAX_BODIES cells. Append shifts the new body into the
// head cell unless the tail cell already holds one, clear drops every valid bit;
// both answer with a transaction at once. Evaluate rotates the ring exactly
// once around, so the bodies return to their places, and works on the body in
// the tail cell: squared distance (two 32x32 multipliers plus the coupling-mass
// product), saturating sum, a bit-serial square root, a bit-serial divide and
// accumulate. Empty cells and the cells after a saturation skip the arithmetic;
// a body whose coupling-mass product is zero stops after the root, and a zero
// root (zero distance with zero softening) saturates the result.
// Sum order does not change the result since terms are nonnegative.
// Registers: coupling at byte 0, softening_sq at byte 4, written with an APB
// access; pready is always high.
`timescale 1ns / 1ps
`default_nettype none

module softened_potential_field_eval_unit
  import spfe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [31:0]        mass_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [47:0] potential_o,
  output logic [1:0]         status_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_VISIT = 7'b0000010,
    ST_SUM   = 7'b0000100,
    ST_SQRT  = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_ACC   = 7'b0100000,
    ST_NEXT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // ---------------- configuration port ----------------
  logic [23:0] coupling_q;
  logic [31:0] soft_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coupling_q <= COUPLING_RST;
      soft_q     <= SOFTENING_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_COUPLING:  coupling_q <= pwdata[23:0];
        REG_SOFTENING: soft_q     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COUPLING:  prdata = {8'd0, coupling_q};
      REG_SOFTENING: prdata = soft_q;
      default:       prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // ---------------- body ring ----------------
  body_t cell_in  [MAX_BODIES];
  body_t cell_out [MAX_BODIES];
  logic  ring_shift, ring_clear, do_append;
  body_t tail;

  assign tail = cell_out[MAX_BODIES-1];

  generate
    for (genvar i = 0; i < MAX_BODIES; i++) begin : g_cell
      if (i == 0) begin : g_head
        // append feeds the head, rotation closes the ring
        assign cell_in[i] = do_append ?
          body_t'{valid: 1'b1, x: pos_x_i, z: pos_z_i, mass: mass_i} : tail;
      end else begin : g_body
        assign cell_in[i] = cell_out[i-1];
      end
      spfe_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (ring_shift),
        .clear_i (ring_clear),
        .body_i  (cell_in[i]),
        .body_o  (cell_out[i])
      );
    end
  endgenerate

  // ---------------- arithmetic units ----------------
  unit_ctrl_t  sqrt_ctrl, div_ctrl;
  unit_stat_t  sqrt_stat, div_stat;
  logic [63:0] r2_q;
  logic [31:0] root;
  logic [55:0] prod_q, quot;

  spfe_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sqrt_ctrl),
    .rad_i  (r2_q),
    .stat_o (sqrt_stat),
    .root_o (root)
  );

  spfe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (prod_q),
    .divisor_i  (root),
    .stat_o     (div_stat),
    .quot_o     (quot)
  );

  // ---------------- evaluation datapath ----------------
  logic [31:0] qx_q, qz_q;
  logic [63:0] dsx_q, dsz_q;
  logic [32:0] dx, dz;
  logic [31:0] adx, adz;
  logic [64:0] s1;
  logic [63:0] s1_sat;
  logic [64:0] s2;
  logic [56:0] acc_sum;
  logic [47:0] mag_q, mag_d;
  logic        sat_q, sat_d;
  logic [IDX_W-1:0] vis_q, vis_d;
  logic        in_fire, out_free;
  logic        out_valid_q, out_load;
  logic [47:0] out_pot_d, out_pot_q;
  logic [1:0]  out_stat_d, out_stat_q;
  logic        cap_query, cap_sq, cap_r2;

  assign dx  = {qx_q[31], qx_q} - {tail.x[31], tail.x};
  assign dz  = {qz_q[31], qz_q} - {tail.z[31], tail.z};
  assign adx = dx[32] ? 32'(-dx) : dx[31:0];
  assign adz = dz[32] ? 32'(-dz) : dz[31:0];

  // saturating r2 = dx^2 + dz^2 + softening << 16
  assign s1     = {1'b0, dsx_q} + {1'b0, dsz_q};
  assign s1_sat = s1[64] ? '1 : s1[63:0];
  assign s2     = {1'b0, s1_sat} + {17'd0, soft_q, 16'd0};

  assign acc_sum = {9'd0, mag_q} + {1'b0, quot};

  always_ff @(posedge clk_i) begin
    if (cap_query) begin
      qx_q <= pos_x_i;
      qz_q <= pos_z_i;
    end
    if (cap_sq) begin
      dsx_q  <= adx * adx;
      dsz_q  <= adz * adz;
      prod_q <= 56'(coupling_q) * 56'(tail.mass);
    end
    if (cap_r2) begin
      r2_q <= s2[64] ? '1 : s2[63:0];
    end
  end

  // ---------------- control ----------------
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    mag_d      = mag_q;
    sat_d      = sat_q;
    vis_d      = vis_q;
    ring_shift = 1'b0;
    ring_clear = 1'b0;
    do_append  = 1'b0;
    cap_query  = 1'b0;
    cap_sq     = 1'b0;
    cap_r2     = 1'b0;
    sqrt_ctrl  = '{start: 1'b0};
    div_ctrl   = '{start: 1'b0};
    out_load   = 1'b0;
    out_pot_d  = '0;
    out_stat_d = STATUS_OK;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (command_i)
            CMD_CLEAR: begin
              ring_clear = 1'b1;
              out_load   = 1'b1;
            end
            CMD_APPEND: begin
              out_load = 1'b1;
              // store is full once the tail cell holds a body
              if (tail.valid) begin
                out_stat_d = STATUS_FULL;
              end else begin
                do_append  = 1'b1;
                ring_shift = 1'b1;
              end
            end
            CMD_EVAL: begin
              cap_query = 1'b1;
              mag_d     = '0;
              sat_d     = 1'b0;
              vis_d     = '0;
              state_d   = ST_VISIT;
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      ST_VISIT: begin
        if (tail.valid && !sat_q) begin
          cap_sq  = 1'b1;
          state_d = ST_SUM;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_SUM: begin
        cap_r2  = 1'b1;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (!sqrt_stat.busy && !sqrt_stat.done) begin
          sqrt_ctrl = '{start: 1'b1};
        end else if (sqrt_stat.done) begin
          if (prod_q == '0) begin
            state_d = ST_NEXT;
          end else if (root == '0) begin
            sat_d   = 1'b1;
            state_d = ST_NEXT;
          end else begin
            div_ctrl = '{start: 1'b1};
            state_d  = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (acc_sum > 57'(MAG_LIMIT)) begin
          sat_d = 1'b1;
        end else begin
          mag_d = acc_sum[47:0];
        end
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        if (vis_q == IDX_W'(MAX_BODIES - 1)) begin
          // hold the last rotation until the result register frees
          if (out_free) begin
            ring_shift = 1'b1;
            out_load   = 1'b1;
            out_pot_d  = sat_q ? MAG_LIMIT : 48'(-mag_q);
            out_stat_d = sat_q ? STATUS_SAT : STATUS_OK;
            state_d    = ST_IDLE;
          end
        end else begin
          ring_shift = 1'b1;
          vis_d      = vis_q + IDX_W'(1);
          state_d    = ST_VISIT;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      sat_q       <= 1'b0;
      vis_q       <= '0;
    end else begin
      state_q <= state_d;
      sat_q   <= sat_d;
      vis_q   <= vis_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    if (out_load) begin
      out_pot_q  <= out_pot_d;
      out_stat_q <= out_stat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign potential_o = out_pot_q;
  assign status_o    = out_stat_q;

endmodule

`default_nettype wire
